// ===== hw/rtl/dgbs_pkg.sv =====
// Package for the dithered gamma brightness scaler.
// Shared widths, constants and the gamma parameter struct; no dependencies.
package dgbs_pkg;

    localparam int unsigned BRIGHT_W = 10;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned SQUARE_W = 2 * BRIGHT_W;
    localparam int unsigned FRAC_W   = 2;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 10'd1023;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = BRIGHT_MAX;
    localparam logic [SQUARE_W-1:0] SQUARE_RESET = 20'd1046529;  // 1023 * 1023
    localparam logic [CHAN_W-1:0]   BASE_MAX     = 8'd255;

    // dither fraction codes
    localparam logic [FRAC_W-1:0] FRAC_NONE = 2'd0;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] base;
        logic [FRAC_W-1:0] frac;
    } gamma_t;

    localparam gamma_t GAMMA_RESET = '{base: BASE_MAX, frac: FRAC_NONE};

endpackage

// ===== hw/rtl/dgbs_if.sv =====
// Handshake channel interfaces: config write, pixel in, pixel out.
// Depends on dgbs_pkg for field widths.
interface dgbs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dgbs_pkg::BRIGHT_W-1:0] brightness;

    modport source (output valid, output brightness, input ready);
    modport sink   (input valid, input brightness, output ready);
endinterface

interface dgbs_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [dgbs_pkg::CHAN_W-1:0] red;
    logic [dgbs_pkg::CHAN_W-1:0] green;
    logic [dgbs_pkg::CHAN_W-1:0] blue;
    logic                        last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, output ready);
endinterface

interface dgbs_result_if;
    logic                        valid;
    logic                        ready;
    logic [dgbs_pkg::CHAN_W-1:0] red_out;
    logic [dgbs_pkg::CHAN_W-1:0] green_out;
    logic [dgbs_pkg::CHAN_W-1:0] blue_out;
    logic                        last_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output last_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input last_out, output ready);
endinterface

// ===== hw/rtl/dgbs_gamma.sv =====
// Brightness to gamma level: g = round(b*b/1023), split into base and fraction.
// Two register stages (square, then divide). Depends on dgbs_pkg.
module dgbs_gamma
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dgbs_pkg::BRIGHT_W-1:0] brightness,
    output dgbs_pkg::gamma_t              gamma
);

    logic [dgbs_pkg::SQUARE_W-1:0] square_reg;
    logic [dgbs_pkg::SQUARE_W-1:0] square_next;
    dgbs_pkg::gamma_t              gamma_reg;
    dgbs_pkg::gamma_t              gamma_next;

    logic [dgbs_pkg::SQUARE_W:0]   rounded;
    logic [10:0]                   quot0;
    logic [11:0]                   rem;
    logic [9:0]                    level;

    assign square_next = dgbs_pkg::SQUARE_W'(brightness) * dgbs_pkg::SQUARE_W'(brightness);

    // x/1023 = x>>10 plus a correction: remainder is (x mod 1024) + (x>>10)
    always_comb
    begin
        rounded = {1'b0, square_reg} + 21'd511;
        quot0   = rounded[20:10];
        rem     = {2'b00, rounded[9:0]} + {1'b0, quot0};
        if (rem >= 12'd2046)
            level = quot0[9:0] + 10'd2;
        else if (rem >= 12'd1023)
            level = quot0[9:0] + 10'd1;
        else
            level = quot0[9:0];
        gamma_next.base = level[9:2];
        gamma_next.frac = (level[9:2] == dgbs_pkg::BASE_MAX) ? dgbs_pkg::FRAC_NONE : level[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg <= dgbs_pkg::SQUARE_RESET;
            gamma_reg  <= dgbs_pkg::GAMMA_RESET;
        end
        else
        begin
            square_reg <= square_next;
            gamma_reg  <= gamma_next;
        end
    end

    assign gamma = gamma_reg;

endmodule

// ===== hw/rtl/dgbs_lane.sv =====
// One color lane: c * (1 + scale) >> 8 into an output register.
// Depends on dgbs_pkg.
module dgbs_lane
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [dgbs_pkg::CHAN_W-1:0] chan,
    input  logic [dgbs_pkg::CHAN_W:0]   factor,
    output logic [dgbs_pkg::CHAN_W-1:0] chan_out
);

    logic [2*dgbs_pkg::CHAN_W:0]   product;
    logic [dgbs_pkg::CHAN_W-1:0]   chan_reg;
    logic [dgbs_pkg::CHAN_W-1:0]   chan_next;

    assign product   = (2*dgbs_pkg::CHAN_W+1)'(chan) * (2*dgbs_pkg::CHAN_W+1)'(factor);
    assign chan_next = product[2*dgbs_pkg::CHAN_W-1:dgbs_pkg::CHAN_W];

    always_ff @(posedge clk)
    begin
        if (load)
            chan_reg <= chan_next;
    end

    assign chan_out = chan_reg;

endmodule

// ===== hw/rtl/dithered_gamma_brightness_scaler.sv =====
// Dithered gamma brightness scaler: takes one RGB pixel per beat and scales all
// three channels by a gamma-corrected global brightness with 4-phase spatial
// dithering. Throughput is one pixel per clock while result.ready is high. There
// are three register stages: a beat goes through s1 and s2 into the output register.
// A brightness write is accepted in any cycle
// (cfg.ready is tied high) and passes through a two-stage gamma unit (square,
// then divide by 1023); pixels accepted from the next cycle on see the new value.
// Three lanes do the per-channel multiply, and their registers together with the
// last flag form the output stage. Depends on dgbs_pkg and dgbs_if.
module dithered_gamma_brightness_scaler
(
    input  logic                 clk,
    input  logic                 rst_n,
    dgbs_cfg_if.sink             cfg,
    dgbs_pixel_if.sink           pixel,
    dgbs_result_if.source        result
);

    // config register
    logic [dgbs_pkg::BRIGHT_W-1:0] brightness_reg;
    dgbs_pkg::gamma_t              gamma;

    // stage 1: accepted beat plus its dither phase
    logic                        s1_valid_reg;
    logic [dgbs_pkg::CHAN_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic                        s1_last_reg;
    logic [1:0]                  s1_phase_reg;

    // stage 2: a beat accepted after a write meets its settled gamma level here
    logic                        s2_valid_reg;
    logic [dgbs_pkg::CHAN_W-1:0] s2_red_reg, s2_green_reg, s2_blue_reg;
    logic                        s2_last_reg;
    logic [1:0]                  s2_phase_reg;

    // stage 3: output register (lanes hold the channel data)
    logic                        s3_valid_reg;
    logic                        s3_last_reg;

    logic [1:0]                  phase_reg;
    logic [1:0]                  phase_next;

    logic                        in_fire;
    logic                        adv3;
    logic                        adv2;
    logic                        adv1;
    logic                        dither;
    logic [dgbs_pkg::CHAN_W-1:0] scale;
    logic [dgbs_pkg::CHAN_W:0]   factor;

    // bubble-collapsing advance chain
    assign adv3        = !s3_valid_reg || result.ready;
    assign adv2        = !s2_valid_reg || adv3;
    assign adv1        = !s1_valid_reg || adv2;
    assign pixel.ready = adv1;
    assign in_fire     = pixel.valid && adv1;
    assign cfg.ready   = 1'b1;

    // position counter, cleared after the last pixel of a frame
    assign phase_next = pixel.last_pixel ? 2'd0 : phase_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= dgbs_pkg::BRIGHT_RESET;
            phase_reg      <= 2'd0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                brightness_reg <= cfg.brightness;
            if (in_fire)
                phase_reg <= phase_next;
            if (adv1)
                s1_valid_reg <= pixel.valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_red_reg   <= pixel.red;
            s1_green_reg <= pixel.green;
            s1_blue_reg  <= pixel.blue;
            s1_last_reg  <= pixel.last_pixel;
            s1_phase_reg <= phase_reg;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_red_reg   <= s1_red_reg;
            s2_green_reg <= s1_green_reg;
            s2_blue_reg  <= s1_blue_reg;
            s2_last_reg  <= s1_last_reg;
            s2_phase_reg <= s1_phase_reg;
        end
        if (adv3 && s2_valid_reg)
            s3_last_reg <= s2_last_reg;
    end

    dgbs_gamma u_gamma
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .brightness (brightness_reg),
        .gamma      (gamma)
    );

    // Dither: half fraction bumps even positions; quarter fractions bump
    // positions below the fraction. Base is never 255 with a nonzero fraction.
    always_comb
    begin
        if (gamma.frac == dgbs_pkg::FRAC_HALF)
            dither = !s2_phase_reg[0];
        else if (gamma.frac != dgbs_pkg::FRAC_NONE)
            dither = (s2_phase_reg < gamma.frac);
        else
            dither = 1'b0;
        scale  = gamma.base + dgbs_pkg::CHAN_W'(dither);
        factor = {1'b0, scale} + 9'd1;
    end

    dgbs_lane u_lane_red
    (
        .clk      (clk),
        .load     (adv3 && s2_valid_reg),
        .chan     (s2_red_reg),
        .factor   (factor),
        .chan_out (result.red_out)
    );

    dgbs_lane u_lane_green
    (
        .clk      (clk),
        .load     (adv3 && s2_valid_reg),
        .chan     (s2_green_reg),
        .factor   (factor),
        .chan_out (result.green_out)
    );

    dgbs_lane u_lane_blue
    (
        .clk      (clk),
        .load     (adv3 && s2_valid_reg),
        .chan     (s2_blue_reg),
        .factor   (factor),
        .chan_out (result.blue_out)
    );

    // merge: lanes and last flag leave together as one beat
    assign result.valid    = s3_valid_reg;
    assign result.last_out = s3_last_reg;

endmodule

// ===== verif/tb.sv =====
// Testbench for dithered_gamma_brightness_scaler: random and directed pixel beats,
// checked against a gamma-and-dither predictor in a small scoreboard class.
// Depends on dgbs_pkg, the dgbs_if interfaces and the scaler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One pixel beat; the same fields travel in and out of the scaler.
    typedef struct packed {
        logic [dgbs_pkg::CHAN_W-1:0] red;
        logic [dgbs_pkg::CHAN_W-1:0] green;
        logic [dgbs_pkg::CHAN_W-1:0] blue;
        logic                        last;
    } pixel_t;

    // Tracks brightness and dither position and holds the scaled pixels still owed.
    class scaled_pixel_tracker;
        logic [dgbs_pkg::BRIGHT_W-1:0] brightness;
        logic [1:0]                    position;
        pixel_t                        scaled_q[$];
        int unsigned                   fails;

        function new();
            brightness = dgbs_pkg::BRIGHT_RESET;
            position   = '0;
            fails      = 0;
        endfunction

        function void set_brightness(input logic [dgbs_pkg::BRIGHT_W-1:0] value);
            brightness = value;
        endfunction

        function int unsigned pending();
            return scaled_q.size();
        endfunction

        // Only the first ten failures get a line; the rest are counted.
        function void flag(input string msg);
            fails++;
            if (fails <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        // Gamma curve plus spatial dither: scale for the pixel at the current position.
        function int unsigned dithered_scale();
            int unsigned b;
            int unsigned g;
            int unsigned base;
            logic [dgbs_pkg::FRAC_W-1:0] frac;
            int unsigned s;
            b    = brightness;
            g    = (b * b + dgbs_pkg::BRIGHT_MAX / 2) / dgbs_pkg::BRIGHT_MAX;  // round
            base = g >> 2;
            frac = (base != dgbs_pkg::BASE_MAX) ? dgbs_pkg::FRAC_W'(g & 3)
                                                : dgbs_pkg::FRAC_NONE;
            s    = base;
            if (frac == dgbs_pkg::FRAC_HALF)
            begin
                if (position[0] == 1'b0)
                    s = base + 1;
            end
            else if (frac != dgbs_pkg::FRAC_NONE)
            begin
                if (position < frac)
                    s = base + 1;
            end
            if (s > dgbs_pkg::BASE_MAX)
                s = dgbs_pkg::BASE_MAX;
            return s;
        endfunction

        function logic [dgbs_pkg::CHAN_W-1:0] scale_chan(
            input logic [dgbs_pkg::CHAN_W-1:0] c,
            input int unsigned s);
            int unsigned prod;
            prod = c * (s + 1);
            return dgbs_pkg::CHAN_W'(prod >> 8);
        endfunction

        // Accepted input beat: predict its output and advance the dither position.
        function void note_pixel(input pixel_t px);
            int unsigned s;
            pixel_t      exp_px;
            s            = dithered_scale();
            exp_px.red   = scale_chan(px.red, s);
            exp_px.green = scale_chan(px.green, s);
            exp_px.blue  = scale_chan(px.blue, s);
            exp_px.last  = px.last;
            scaled_q.push_back(exp_px);
            position = px.last ? 2'd0 : position + 2'd1;
        endfunction

        // Accepted output beat: compare with the oldest prediction.
        function void check_result(input pixel_t got);
            pixel_t exp_px;
            if (scaled_q.size() == 0)
            begin
                flag($sformatf("unexpected beat r=%0d g=%0d b=%0d last=%0b",
                               got.red, got.green, got.blue, got.last));
                return;
            end
            exp_px = scaled_q.pop_front();
            if (got.red !== exp_px.red || got.green !== exp_px.green ||
                got.blue !== exp_px.blue || got.last !== exp_px.last)
                flag($sformatf({"expected r=%0d g=%0d b=%0d last=%0b, ",
                                "got r=%0d g=%0d b=%0d last=%0b"},
                               exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                               got.red, got.green, got.blue, got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dgbs_cfg_if    cfg_ch ();
    dgbs_pixel_if  pix_ch ();
    dgbs_result_if res_ch ();

    dithered_gamma_brightness_scaler u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixel  (pix_ch),
        .result (res_ch)
    );

    scaled_pixel_tracker book = new();

    // Percent of cycles in which the sender holds off / the receiver stalls.
    int unsigned send_gap_pct   = 14;
    int unsigned recv_stall_pct = 64;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run (~1.6k beats).
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: ready redrawn at every falling edge.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor: flops update by NBA, so values seen here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            book.check_result('{red: res_ch.red_out, green: res_ch.green_out,
                                blue: res_ch.blue_out, last: res_ch.last_out});
    end

    // Entered and left at a falling edge; valid stays high from one beat to the next
    // unless a gap is drawn.
    task automatic send_pixel(input logic [dgbs_pkg::CHAN_W-1:0] r,
                              input logic [dgbs_pkg::CHAN_W-1:0] g,
                              input logic [dgbs_pkg::CHAN_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pix_ch.valid = 1'b0;
            @(negedge clk);
        end
        pix_ch.valid      = 1'b1;
        pix_ch.red        = r;
        pix_ch.green      = g;
        pix_ch.blue       = b;
        pix_ch.last_pixel = last;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        book.note_pixel('{red: r, green: g, blue: b, last: last});
        @(negedge clk);
    endtask

    // Sender holds off until every predicted beat has come out.
    task automatic wait_drained();
        pix_ch.valid = 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    // Brightness is only changed with nothing in flight.
    task automatic write_brightness(input logic [dgbs_pkg::BRIGHT_W-1:0] value);
        wait_drained();
        cfg_ch.valid      = 1'b1;
        cfg_ch.brightness = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        book.set_brightness(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Channel values lean toward the extremes now and then.
    function automatic logic [dgbs_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return dgbs_pkg::CHAN_W'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        logic [dgbs_pkg::BRIGHT_W-1:0] setting;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.brightness = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.red        = '0;
        pix_ch.green      = '0;
        pix_ch.blue       = '0;
        pix_ch.last_pixel = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full brightness out of reset: g = 1023, base 255, fraction dropped.
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd128, 1'b0);
        send_pixel(8'd1,   8'd127, 8'd255, 1'b1);
        send_pixel(8'hAA,  8'h55,  8'h01,  1'b0);
        send_pixel(8'h55,  8'hAA,  8'h80,  1'b1);

        // Half fraction (g = 2): extra step on even positions only.
        write_brightness(10'd45);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd200, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd200, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

        // Base 254 with fraction 3: scale saturates at 255 on the first three positions.
        write_brightness(10'd1021);
        send_pixel(8'd255, 8'd1,   8'd128, 1'b0);
        send_pixel(8'd255, 8'd1,   8'd128, 1'b0);
        send_pixel(8'd255, 8'd1,   8'd128, 1'b0);
        send_pixel(8'd255, 8'd1,   8'd128, 1'b0);
        send_pixel(8'd255, 8'd1,   8'd128, 1'b1);

        // g = 1021: base 255, so the fraction of 1 must be forced off.
        write_brightness(10'd1022);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd254, 8'd2,   8'd129, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

        // Zero brightness: scale 0, everything collapses to c >> 8.
        write_brightness(10'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd1,   8'd0,   1'b1);

        // Random part: eight brightness phases, idle profile swapped along the way.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       setting = 10'd1;       // g = 0
                1:       setting = 10'd32;      // fraction 1
                2:       setting = 10'd55;      // fraction 3
                3:       setting = 10'd1020;    // base 254, fraction 1
                7:       setting = dgbs_pkg::BRIGHT_MAX;
                default: setting = dgbs_pkg::BRIGHT_W'(
                                       $urandom_range(dgbs_pkg::BRIGHT_MAX));
            endcase
            if (ph < 3)
            begin
                send_gap_pct   = 14;
                recv_stall_pct = 64;
            end
            else if (ph < 6)
            begin
                send_gap_pct   = 64;
                recv_stall_pct = 14;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_brightness(setting);
            for (int k = 0; k < 200; k++)
            begin
                // Mid-stream, let the pipe run completely dry once.
                if (ph == 4 && k == 100)
                    wait_drained();
                send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(4) == 0);
            end
        end

        wait_drained();
        // Pipe is three deep; waiting on past the drain catches any stray output beat.
        repeat (8) @(negedge clk);
        if (book.pending() != 0)
            book.flag($sformatf("%0d predicted beats never came out", book.pending()));

        if (book.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dgbs_pkg.sv
hw/rtl/dgbs_if.sv
hw/rtl/dgbs_gamma.sv
hw/rtl/dgbs_lane.sv
hw/rtl/dithered_gamma_brightness_scaler.sv
verif/tb.sv
